// ----- hw/rtl/pspu_pkg.sv -----
// ----------------------------------------------------------------------------
// pspu_pkg
// Shared types and constants of the pulse shaper and carrier upconverter.
// ----------------------------------------------------------------------------
package pspu_pkg;

	// interpolation is fixed at four phases per symbol
	localparam int UPSAMPLE_FACTOR = 4;
	localparam int K_W             = 2;

	// default sizes of the filter and the sine table
	localparam int FILTER_TAPS_DEF      = 64;
	localparam int SINE_TABLE_DEPTH_DEF = 1024;

	// register reset values and limits
	localparam logic [31:0] PHASE_STEP_RST = 32'd805306368;
	localparam logic [12:0] BLOCK_SIZE_RST = 13'd1024;
	localparam logic [12:0] BLOCK_MAX      = 13'd4096;

	// quarter turn of the carrier phase, and pi/2 in Q30
	localparam logic [31:0]    COS_OFFSET  = 32'h4000_0000;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// input item kinds carried on tuser
	localparam logic ACTION_SYMBOL = 1'b0;
	localparam logic ACTION_LOAD   = 1'b1;

	// configuration register indexes
	localparam int         CFG_ADDR_W     = 1;
	localparam logic [0:0] REG_PHASE_STEP = 1'b0;
	localparam logic [0:0] REG_BLOCK_SIZE = 1'b1;

	// stream payload widths
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 16;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_ANG,
		ST_ROM,
		ST_MULC,
		ST_MULS,
		ST_SUB,
		ST_EMIT
	} pspu_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic sym_load;
		logic coef_load;
		logic mac_issue;
		logic ang_cos;
		logic rom_cos;
		logic mul_cos;
		logic mul_sin;
		logic mix_sub;
		logic emit;
	} pspu_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic mac_last;
		logic pipe_empty;
		logic last_phase;
		logic out_free;
	} pspu_sts_t;

endpackage

// ----- hw/rtl/psk_pulse_shape_upconvert.sv -----
// ----------------------------------------------------------------------------
// psk_pulse_shape_upconvert
// Polyphase x4 interpolating FIR pulse shaper with sine-table carrier mixer.
// ----------------------------------------------------------------------------
// Each of the four samples of a symbol takes one complex MAC pass over the
//   delay line; no new item is taken until the last sample is emitted, and
//   output stalls hold the sample in the emit state.
// A coefficient load produces no sample.
// Reset (arst_n low, asynchronous): delay line reads as zeros through a fill
//   count, phase and block position clear; coefficients are kept, no sweep.
module psk_pulse_shape_upconvert
	import pspu_pkg::*;
#(
	parameter int FILTER_TAPS      = FILTER_TAPS_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [31:0]            cfg_wdata,
	// input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // symbol_re, symbol_im, coeff_index,
	                                               // coeff_value, zero pad
	input  logic                   s_axis_tuser,  // action
	// output stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // sample
	output logic                   m_axis_tlast,  // last_of_symbol
	output logic                   m_axis_tuser   // block_end
);

	pspu_cmd_t          cmd;
	pspu_sts_t          sts;
	logic signed [15:0] out_sample;

	// sequencer
	pspu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_action(s_axis_tuser),
		.sts      (sts),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	// datapath
	pspu_dp #(
		.FILTER_TAPS     (FILTER_TAPS),
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.symbol_re    (s_axis_tdata[15:0]),
		.symbol_im    (s_axis_tdata[31:16]),
		.coeff_index  (s_axis_tdata[37:32]),
		.coeff_value  (s_axis_tdata[53:38]),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_sample   (out_sample),
		.out_last     (m_axis_tlast),
		.out_block_end(m_axis_tuser)
	);

	assign m_axis_tdata = out_sample;

	// a sample is never written over one still waiting at the output
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("sample emitted over a pending output transfer");

	// no input transfer while a symbol is still being worked on
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !s_axis_tready)
		else $error("input ready during sample production");

	// the fourth sample of a symbol returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.last_phase) |=> s_axis_tready)
		else $error("not idle after last sample of a symbol");

	// stores are written only on an accepted input transfer
	a_load_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sym_load || cmd.coef_load) |-> (s_axis_tvalid && s_axis_tready))
		else $error("store written without an input transfer");

endmodule

// ----- hw/rtl/pspu_ram.sv -----
// ----------------------------------------------------------------------------
// pspu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pspu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/pspu_ctrl.sv -----
// ----------------------------------------------------------------------------
// pspu_ctrl
// Sequencer: accepts items, steps the filter pass, mixer and sample output.
// ----------------------------------------------------------------------------
module pspu_ctrl
	import pspu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_action,
	input  pspu_sts_t sts,
	output logic      in_ready,
	output pspu_cmd_t cmd
);

	pspu_state_t state_q;
	pspu_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_action == ACTION_SYMBOL) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (sts.mac_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) begin
					state_d = ST_ANG;
				end
			end
			ST_ANG:  state_d = ST_ROM;
			ST_ROM:  state_d = ST_MULC;
			ST_MULC: state_d = ST_MULS;
			ST_MULS: state_d = ST_SUB;
			ST_SUB:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = sts.last_phase ? ST_IDLE : ST_MAC;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.sym_load  = in_valid && in_action == ACTION_SYMBOL;
				cmd.coef_load = in_valid && in_action == ACTION_LOAD;
			end
			ST_MAC:   cmd.mac_issue = 1'b1;
			ST_DRAIN: cmd = '0;
			ST_ANG:   cmd.ang_cos = 1'b1;
			ST_ROM:   cmd.rom_cos = 1'b1;
			ST_MULC:  cmd.mul_cos = 1'b1;
			ST_MULS:  cmd.mul_sin = 1'b1;
			ST_SUB:   cmd.mix_sub = 1'b1;
			ST_EMIT:  cmd.emit = sts.out_free;
			default:  cmd = '0;
		endcase
	end

endmodule

// ----- hw/rtl/pspu_dp.sv -----
// ----------------------------------------------------------------------------
// pspu_dp
// Datapath: delay line, coefficient store, complex MAC, sine table mixer,
// carrier phase, block counter and output register.
// ----------------------------------------------------------------------------
module pspu_dp
	import pspu_pkg::*;
#(
	parameter int FILTER_TAPS      = FILTER_TAPS_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pspu_cmd_t             cmd,
	output pspu_sts_t             sts,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [31:0]           cfg_wdata,
	input  logic signed [15:0]    symbol_re,
	input  logic signed [15:0]    symbol_im,
	input  logic [5:0]            coeff_index,
	input  logic signed [15:0]    coeff_value,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic signed [15:0]    out_sample,
	output logic                  out_last,
	output logic                  out_block_end
);

	localparam int L      = FILTER_TAPS / UPSAMPLE_FACTOR;
	localparam int LA     = $clog2(L);
	localparam int CA     = $clog2(FILTER_TAPS);
	localparam int SA     = $clog2(SINE_TABLE_DEPTH);
	localparam int DW     = $clog2(SINE_TABLE_DEPTH) + 1;
	localparam int ACC_W  = 32 + $clog2(L);
	localparam int MUL_W  = ACC_W + 16;
	localparam int MIX_W  = ACC_W + 17;
	localparam int SH_W   = MIX_W - 31;

	localparam logic [LA:0]               L_V     = (LA + 1)'(L);
	localparam logic [DW-1:0]             DEPTH_V = DW'(SINE_TABLE_DEPTH);
	localparam logic signed [MIX_W-1:0]   MIX_RND = MIX_W'(2 ** 30);
	localparam logic signed [SH_W-1:0]    SAT_HI  = SH_W'(32767);
	localparam logic signed [SH_W-1:0]    SAT_LO  = SH_W'(-32768);

	typedef logic signed [15:0] rom_t [SINE_TABLE_DEPTH];

	// sine table entry n: fixed-point Taylor series over a quarter wave
	function automatic rom_t build_rom();
		rom_t            rom;
		longint unsigned frac;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint          s;
		logic [1:0]      quad;
		for (int n = 0; n < SINE_TABLE_DEPTH; n++) begin
			frac = ($unsigned(64'(n)) << 32) / SINE_TABLE_DEPTH;
			quad = 2'(frac >> 30);
			r    = frac & 64'h3FFF_FFFF;
			x    = (r * HALF_PI_Q30) >> 30;
			if (quad[0]) begin
				x = HALF_PI_Q30 - x;
			end
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int k = 1; k <= 6; k++) begin
				// term divided by (2k)(2k+1)
				case (k)
					1:       term = ((term * x2) >> 30) / 64'd6;
					2:       term = ((term * x2) >> 30) / 64'd20;
					3:       term = ((term * x2) >> 30) / 64'd42;
					4:       term = ((term * x2) >> 30) / 64'd72;
					5:       term = ((term * x2) >> 30) / 64'd110;
					default: term = ((term * x2) >> 30) / 64'd156;
				endcase
				if (k % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			s = (sum + 64'sd16384) >>> 15;
			if (s > 64'sd32767) begin
				s = 64'sd32767;
			end
			rom[n] = quad[1] ? -16'(s) : 16'(s);
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// configuration registers
	logic [31:0] phase_step_q;
	logic [12:0] block_size_q;

	// delay line bookkeeping and MAC sequencing
	logic [LA-1:0]  wp_q;
	logic [LA:0]    fill_q;
	logic [LA-1:0]  i_q;
	logic [K_W-1:0] k_q;
	logic [LA:0]    line_sum;
	logic [LA-1:0]  line_raddr;
	logic [CA-1:0]  coef_raddr;
	logic [31:0]    line_rdata;
	logic [15:0]    coef_rdata;
	logic           coef_ok;

	// MAC pipeline
	logic                    v_s1;
	logic                    first_s1;
	logic                    live_s1;
	logic                    v_s2;
	logic                    first_s2;
	logic signed [31:0]      prod_re_s2;
	logic signed [31:0]      prod_im_s2;
	logic signed [15:0]      line_re;
	logic signed [15:0]      line_im;
	logic signed [15:0]      coef;
	logic signed [ACC_W-1:0] acc_re_q;
	logic signed [ACC_W-1:0] acc_im_q;

	// mixer
	logic [31:0]             phase_q;
	logic [31:0]             ang_phase;
	logic [31+DW:0]          ang_prod;
	logic [SA-1:0]           idx_q;
	logic signed [15:0]      trig_q;
	logic signed [ACC_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_q;
	logic signed [MUL_W-1:0] pa_q;
	logic signed [MIX_W-1:0] diff_q;
	logic signed [SH_W-1:0]  shifted;
	logic signed [15:0]      sat_sample;

	// block counter
	logic [11:0] pos_q;
	logic [12:0] size_eff;
	logic        blk_end;

	// output register
	logic               out_valid_q;
	logic signed [15:0] sample_q;
	logic               last_q;
	logic               block_end_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PHASE_STEP_RST;
			block_size_q <= BLOCK_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PHASE_STEP: phase_step_q <= cfg_wdata;
				REG_BLOCK_SIZE: block_size_q <= cfg_wdata[12:0];
				default:        phase_step_q <= phase_step_q;
			endcase
		end
	end

	// circular delay line: oldest entry sits at the write pointer
	always_comb begin
		line_sum = {1'b0, wp_q} + {1'b0, i_q};
		if (line_sum >= L_V) begin
			line_sum = line_sum - L_V;
		end
		line_raddr = line_sum[LA-1:0];
		coef_raddr = CA'({i_q, k_q});
		coef_ok    = 32'(coeff_index) < 32'(FILTER_TAPS);
	end

	pspu_ram #(
		.WIDTH(32),
		.DEPTH(L)
	) u_line_ram (
		.clk  (clk),
		.we   (cmd.sym_load),
		.waddr(wp_q),
		.wdata({symbol_im, symbol_re}),
		.raddr(line_raddr),
		.rdata(line_rdata)
	);

	pspu_ram #(
		.WIDTH(16),
		.DEPTH(FILTER_TAPS)
	) u_coef_ram (
		.clk  (clk),
		.we   (cmd.coef_load && coef_ok),
		.waddr(CA'(coeff_index)),
		.wdata(coeff_value),
		.raddr(coef_raddr),
		.rdata(coef_rdata)
	);

	// write pointer, fill count, tap and phase counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			i_q    <= '0;
			k_q    <= '0;
		end else begin
			if (cmd.sym_load) begin
				wp_q <= (wp_q == LA'(L - 1)) ? '0 : wp_q + 1'b1;
				if (fill_q != L_V) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.mac_issue) begin
				i_q <= (i_q == LA'(L - 1)) ? '0 : i_q + 1'b1;
			end
			if (cmd.emit) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// MAC pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.mac_issue;
			v_s2 <= v_s1;
		end
	end

	assign line_re = line_rdata[15:0];
	assign line_im = line_rdata[31:16];
	assign coef    = coef_rdata;

	// read stage tags, product stage, accumulate; unfilled entries read as zero
	always_ff @(posedge clk) begin
		first_s1   <= i_q == '0;
		live_s1    <= (LA + 1)'(i_q) >= L_V - fill_q;
		first_s2   <= first_s1;
		prod_re_s2 <= live_s1 ? line_re * coef : 32'sd0;
		prod_im_s2 <= live_s1 ? line_im * coef : 32'sd0;
		if (v_s2) begin
			acc_re_q <= first_s2 ? ACC_W'(prod_re_s2) : acc_re_q + ACC_W'(prod_re_s2);
			acc_im_q <= first_s2 ? ACC_W'(prod_im_s2) : acc_im_q + ACC_W'(prod_im_s2);
		end
	end

	// sine table address: floor(phase * depth / 2^32)
	always_comb begin
		ang_phase = cmd.ang_cos ? phase_q + COS_OFFSET : phase_q;
		ang_prod  = (32 + DW)'(ang_phase) * (32 + DW)'(DEPTH_V);
		mul_a     = cmd.mul_sin ? acc_im_q : acc_re_q;
	end

	// cosine then sine lookup, one shared multiplier, difference with rounding
	always_ff @(posedge clk) begin
		if (cmd.ang_cos || cmd.rom_cos) begin
			idx_q <= SA'(ang_prod >> 32);
		end
		if (cmd.rom_cos || cmd.mul_cos) begin
			trig_q <= SINE_ROM[idx_q];
		end
		if (cmd.mul_cos || cmd.mul_sin) begin
			mul_q <= mul_a * trig_q;
		end
		if (cmd.mul_sin) begin
			pa_q <= mul_q;
		end
		if (cmd.mix_sub) begin
			diff_q <= MIX_W'(pa_q) - MIX_W'(mul_q) + MIX_RND;
		end
	end

	// scale by 2^-31 and saturate to Q1.15
	always_comb begin
		shifted = SH_W'(diff_q >>> 31);
		if (shifted > SAT_HI) begin
			sat_sample = 16'sh7FFF;
		end else if (shifted < SAT_LO) begin
			sat_sample = -16'sh8000;
		end else begin
			sat_sample = shifted[15:0];
		end
	end

	// block size out of range counts as the maximum
	always_comb begin
		size_eff = (block_size_q == '0 || block_size_q > BLOCK_MAX) ? BLOCK_MAX : block_size_q;
		blk_end  = {1'b0, pos_q} + 13'd1 >= size_eff;
	end

	// carrier phase, block position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				phase_q     <= phase_q + phase_step_q;
				pos_q       <= blk_end ? '0 : pos_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sample_q    <= sat_sample;
			last_q      <= k_q == K_W'(UPSAMPLE_FACTOR - 1);
			block_end_q <= blk_end;
		end
	end

	assign sts.mac_last   = i_q == LA'(L - 1);
	assign sts.pipe_empty = !v_s1 && !v_s2;
	assign sts.last_phase = k_q == K_W'(UPSAMPLE_FACTOR - 1);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign out_sample    = sample_q;
	assign out_last      = last_q;
	assign out_block_end = block_end_q;

endmodule

// ----- verif/pspu_sample_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pspu_sample_checker
// Watches the input and output streams and the register port of the pulse
// shaper, predicts every passband sample of each symbol transfer and compares
// the output transfers field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pspu_sample_checker
	import pspu_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [31:0]            cfg_wdata,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // symbol_re, symbol_im, coeff_index,
	                                               // coeff_value, zero pad
	input  logic                   s_axis_tuser,  // action
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // sample
	input  logic                   m_axis_tlast,  // last_of_symbol
	input  logic                   m_axis_tuser,  // block_end
	output int                     fail_count,
	output int                     pending,
	output int                     symbol_cnt,
	output int                     load_cnt,
	output int                     sample_cnt,
	output int                     block_end_cnt,
	output int                     sat_cnt
);

	localparam int TAPS      = FILTER_TAPS_DEF;
	localparam int LUT_DEPTH = SINE_TABLE_DEPTH_DEF;
	localparam int LINE_LEN  = TAPS / UPSAMPLE_FACTOR;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic [15:0] sample;
		logic        last_of_symbol;
		logic        block_end;
	} sample_exp_t;

	logic signed [15:0] sine_lut  [LUT_DEPTH];
	logic signed [15:0] tap_store [TAPS];
	logic signed [15:0] line_re   [LINE_LEN];
	logic signed [15:0] line_im   [LINE_LEN];
	logic [31:0]        carrier_phase;
	logic [31:0]        phase_step;
	logic [12:0]        block_size;
	logic [11:0]        block_pos;
	sample_exp_t        expected_samples [$];

	// sin(x) for x in [0, pi/2], argument and result in Q30
	function automatic longint quarter_sin_q30(u64_t x);
		u64_t   x2;
		u64_t   term;
		longint sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / u64_t'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				sum -= longint'(term);
			else
				sum += longint'(term);
		end
		if (sum < 0)
			sum = 0;
		return sum;
	endfunction

	// table lookup addressed by the top bits of the phase
	function automatic logic signed [15:0] lut_at(logic [31:0] ph);
		u64_t addr;
		addr = (u64_t'(ph) * LUT_DEPTH) >> 32;
		return sine_lut[addr % LUT_DEPTH];
	endfunction

	// quarter-wave table build, zeroed taps to keep arithmetic known
	initial begin
		u64_t   frac;
		u64_t   r;
		u64_t   x;
		longint s;
		int     quad;
		for (int n = 0; n < LUT_DEPTH; n++) begin
			frac = (u64_t'(n) << 32) / LUT_DEPTH;
			quad = int'((frac >> 30) & 3);
			r    = frac & 64'h3FFF_FFFF;
			x    = (r * HALF_PI_Q30) >> 30;
			if (quad % 2 == 1)
				x = HALF_PI_Q30 - x;
			s = quarter_sin_q30(x);
			s = (s + (64'sd1 <<< 14)) >>> 15;
			if (s > 32767)
				s = 32767;
			sine_lut[n] = (quad >= 2) ? -s[15:0] : s[15:0];
		end
		for (int i = 0; i < TAPS; i++)
			tap_store[i] = '0;
	end

	// shift one symbol in and queue the four mixed samples it makes
	task automatic predict_symbol(logic signed [15:0] re, logic signed [15:0] im);
		longint      acc_re;
		longint      acc_im;
		longint      c;
		longint      s;
		longint      v;
		longint      r;
		int          size;
		sample_exp_t e;
		for (int i = 0; i < LINE_LEN - 1; i++) begin
			line_re[i] = line_re[i + 1];
			line_im[i] = line_im[i + 1];
		end
		line_re[LINE_LEN - 1] = re;
		line_im[LINE_LEN - 1] = im;
		size = (block_size == 0 || block_size > BLOCK_MAX) ? int'(BLOCK_MAX) : int'(block_size);
		for (int k = 0; k < UPSAMPLE_FACTOR; k++) begin
			acc_re = 0;
			acc_im = 0;
			for (int i = 0; i < LINE_LEN; i++) begin
				acc_re += longint'(line_re[i]) * longint'(tap_store[i * UPSAMPLE_FACTOR + k]);
				acc_im += longint'(line_im[i]) * longint'(tap_store[i * UPSAMPLE_FACTOR + k]);
			end
			c = lut_at(carrier_phase + COS_OFFSET);
			s = lut_at(carrier_phase);
			// Q2.45 down to Q1.15 with the halving, round half up
			v = acc_re * c - acc_im * s;
			r = (v + (64'sd1 <<< 30)) >>> 31;
			if (r > 32767) begin
				r = 32767;
				sat_cnt++;
			end else if (r < -32768) begin
				r = -32768;
				sat_cnt++;
			end
			e.sample         = r[15:0];
			e.last_of_symbol = (k == UPSAMPLE_FACTOR - 1);
			carrier_phase    = carrier_phase + phase_step;
			if (int'(block_pos) + 1 >= size) begin
				block_pos   = '0;
				e.block_end = 1'b1;
			end else begin
				block_pos   = block_pos + 12'd1;
				e.block_end = 1'b0;
			end
			expected_samples.push_back(e);
		end
	endtask

	// transfer monitor, predictor update and compare
	always @(posedge clk or negedge arst_n) begin
		sample_exp_t got;
		if (!arst_n) begin
			for (int i = 0; i < LINE_LEN; i++) begin
				line_re[i] = '0;
				line_im[i] = '0;
			end
			carrier_phase = '0;
			block_pos     = '0;
			phase_step    = PHASE_STEP_RST;
			block_size    = BLOCK_SIZE_RST;
			expected_samples.delete();
			fail_count    = 0;
			pending       = 0;
			symbol_cnt    = 0;
			load_cnt      = 0;
			sample_cnt    = 0;
			block_end_cnt = 0;
			sat_cnt       = 0;
		end else begin
			// output transfer against the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_samples.size() == 0) begin
					$error("sample transfer with nothing expected: sample %0d",
						$signed(m_axis_tdata));
					fail_count++;
				end else begin
					got = expected_samples.pop_front();
					if (m_axis_tdata !== got.sample) begin
						$error("sample: expected %0d actual %0d",
							$signed(got.sample), $signed(m_axis_tdata));
						fail_count++;
					end
					if (m_axis_tlast !== got.last_of_symbol) begin
						$error("last_of_symbol: expected %0d actual %0d",
							got.last_of_symbol, m_axis_tlast);
						fail_count++;
					end
					if (m_axis_tuser !== got.block_end) begin
						$error("block_end: expected %0d actual %0d",
							got.block_end, m_axis_tuser);
						fail_count++;
					end
					sample_cnt++;
					if (got.block_end)
						block_end_cnt++;
				end
			end
			// input transfer: coefficient load or symbol
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == ACTION_LOAD) begin
					tap_store[s_axis_tdata[37:32]] = s_axis_tdata[53:38];
					load_cnt++;
				end else begin
					predict_symbol(s_axis_tdata[15:0], s_axis_tdata[31:16]);
					symbol_cnt++;
				end
			end
			// register writes
			if (cfg_we) begin
				case (cfg_addr)
					REG_PHASE_STEP: phase_step = cfg_wdata;
					REG_BLOCK_SIZE: block_size = cfg_wdata[12:0];
					default: ;
				endcase
			end
			pending = expected_samples.size();
		end
	end

endmodule

// ----- verif/psk_pulse_shape_upconvert_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psk_pulse_shape_upconvert_tb
// Drives coefficient loads and symbols into the pulse shaper under several
// carrier step and block size settings, with random gaps on both streams and
// one long output hold-off; the checker predicts and compares every sample.
// ----------------------------------------------------------------------------
module psk_pulse_shape_upconvert_tb;
	import pspu_pkg::*;

	localparam int N_PHASES      = 6;
	localparam int SYMS_PER_PH   = 48;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 600;
	localparam int CYCLE_LIMIT   = 400000;

	// carrier steps: stopped, full turn minus one, 1650 Hz, 1500 Hz, random, 1800 Hz
	localparam logic [31:0] STEP_TAB [N_PHASES] = '{
		32'd0, 32'hFFFF_FFFF, 32'd738197504, 32'd671088640, 32'd0, 32'd805306368
	};
	// block sizes: smallest, largest, zero and over-range (both fold to largest), random, 7
	localparam logic [31:0] BSIZE_TAB [N_PHASES] = '{
		32'd1, 32'd4096, 32'd0, 32'd8191, 32'd0, 32'd7
	};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_ADDR_W-1:0]  cfg_addr;
	logic [31:0]            cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;  // symbol_re, symbol_im, coeff_index,
	                                        // coeff_value, zero pad
	logic                   s_axis_tuser;  // action
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // sample
	logic                   m_axis_tlast;  // last_of_symbol
	logic                   m_axis_tuser;  // block_end

	int fail_count;
	int pending;
	int symbol_cnt;
	int load_cnt;
	int sample_cnt;
	int block_end_cnt;
	int sat_cnt;
	int cycle_cnt;
	int setting_cnt;
	bit quiet;
	bit hold_req;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	psk_pulse_shape_upconvert uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	pspu_sample_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending),
		.symbol_cnt    (symbol_cnt),
		.load_cnt      (load_cnt),
		.sample_cnt    (sample_cnt),
		.block_end_cnt (block_end_cnt),
		.sat_cnt       (sat_cnt)
	);

	// run limit
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d samples still expected", cycle_cnt, pending);
			$display("status: fail");
			$finish;
		end
	end

	// output side: random stall bursts, one long hold-off on request
	initial begin
		int hold_cnt;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
					@(negedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	// offer one item, with an optional gap first; returns at the falling edge
	// after its transfer
	task automatic send_item(logic act, logic [15:0] re, logic [15:0] im,
		logic [5:0] idx, logic [15:0] val);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {2'b00, val, idx, im, re};
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	// register write, with cfg_we dropped again before the task returns
	task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// stop offering, let every sample out and the pipeline empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// stimulus
	initial begin
		logic        act;
		logic [15:0] re;
		logic [15:0] im;
		logic [5:0]  idx;
		logic [15:0] val;
		logic [31:0] step;
		logic [31:0] bsize;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = '0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = ACTION_SYMBOL;
		quiet         = 1'b0;
		hold_req      = 1'b0;
		setting_cnt   = 1;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// every tap written before any symbol, full scale
		for (int i = 0; i < FILTER_TAPS_DEF; i++)
			send_item(ACTION_LOAD, '0, '0, i[5:0], 16'h7FFF);

		// directed: extreme symbols, zero, then a run of one symbol to saturate
		send_item(ACTION_SYMBOL, 16'h7FFF, 16'h7FFF, '0, '0);
		send_item(ACTION_SYMBOL, 16'h8000, 16'h8000, '0, '0);
		send_item(ACTION_SYMBOL, 16'h7FFF, 16'h8000, '0, '0);
		send_item(ACTION_SYMBOL, 16'h8000, 16'h7FFF, '0, '0);
		send_item(ACTION_SYMBOL, 16'h0000, 16'h0000, '0, '0);
		repeat (6) send_item(ACTION_SYMBOL, 16'h7FFF, 16'h8000, '0, '0);
		// directed: loads at the index and value extremes
		send_item(ACTION_LOAD, 16'hFFFF, 16'hFFFF, 6'd0, 16'h8000);
		send_item(ACTION_LOAD, '0, '0, 6'd63, 16'h0000);
		send_item(ACTION_LOAD, '0, '0, 6'd31, 16'h0001);
		send_item(ACTION_SYMBOL, 16'h8000, 16'h7FFF, 6'h3F, 16'hFFFF);
		send_item(ACTION_SYMBOL, 16'h0001, 16'hFFFF, '0, '0);

		// random phases under a series of register settings
		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			step  = (ph == 4) ? $urandom : STEP_TAB[ph];
			bsize = (ph == 4) ? $urandom_range(1, 20) : BSIZE_TAB[ph];
			write_reg(REG_PHASE_STEP, step);
			write_reg(REG_BLOCK_SIZE, bsize);
			setting_cnt++;
			if (ph == 2)
				hold_req = 1'b1;
			if (ph == N_PHASES - 1)
				quiet = 1'b1;
			for (int n = 0; n < SYMS_PER_PH; n++) begin
				idx = $urandom_range(0, 63);
				if ($urandom_range(0, 99) < 18) begin
					// coefficient load, mostly small taps to keep samples in range
					act = ACTION_LOAD;
					case ($urandom_range(0, 9))
						0:       val = 16'h7FFF;
						1:       val = 16'h8000;
						2:       val = $urandom;
						default: val = 16'($urandom_range(0, 4095) - 2048);
					endcase
					re = $urandom;
					im = $urandom;
				end else begin
					act = ACTION_SYMBOL;
					case ($urandom_range(0, 9))
						0:       re = 16'h7FFF;
						1:       re = 16'h8000;
						2:       re = 16'($urandom_range(0, 511) - 256);
						default: re = $urandom;
					endcase
					case ($urandom_range(0, 9))
						0:       im = 16'h8000;
						1:       im = 16'h7FFF;
						2:       im = 16'($urandom_range(0, 511) - 256);
						default: im = $urandom;
					endcase
					val = $urandom;
				end
				send_item(act, re, im, idx, val);
			end
		end

		// drain and verdict
		settle();
		$display("covered %0d symbols and %0d coefficient loads over %0d register settings",
			symbol_cnt, load_cnt, setting_cnt);
		$display("checked %0d samples, %0d block ends, %0d saturated, one long output hold-off",
			sample_cnt, block_end_cnt, sat_cnt);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
